@@ src/box_tracking_kalman_filter_top_defines.svh @@
// Assertion macros shared by the checker.
`ifndef BOX_TRACKING_KALMAN_FILTER_TOP_DEFINES_SVH
`define BOX_TRACKING_KALMAN_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BTKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box tracking filter: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define BTKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box tracking filter: next-cycle check failed");

`endif

@@ src/btkf_pkg.sv @@
package btkf_pkg;

    localparam int ACC_W     = 72;
    localparam int DT_FRAC   = 16;
    localparam int DT_W      = 20;
    localparam int VAR_W     = 31;
    localparam int VAL_W     = 32;
    localparam int ERR_W     = 33;
    localparam int SUM_W     = 33;
    localparam int U_W       = 36;
    localparam int MUL_A_W   = 37;
    localparam int MUL_B_W   = 34;
    localparam int MAX_LANES = 5;
    localparam int LANE_W    = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [DT_W-1:0]  RST_FRAME_INTERVAL  = 20'd6554;
    localparam logic [VAR_W-1:0] RST_PROCESS_NOISE   = 31'd1678;
    localparam logic [VAR_W-1:0] RST_NOISE_CENTER    = 31'd1678;
    localparam logic [VAR_W-1:0] RST_NOISE_SHAPE     = 31'd167772;
    localparam logic [VAR_W-1:0] RST_INIT_VAR_CENTER = 31'd33554432;
    localparam logic [VAR_W-1:0] RST_INIT_VAR_SIZE   = 31'd83886080;
    localparam logic [VAR_W-1:0] RST_INIT_VAR_ANGLE  = 31'd94371840;
    localparam logic [VAR_W-1:0] RST_INIT_VAR_RATE   = 31'd16777;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_INTERVAL  = 3'd0,
        CFG_PROCESS_NOISE   = 3'd1,
        CFG_NOISE_CENTER    = 3'd2,
        CFG_NOISE_SHAPE     = 3'd3,
        CFG_INIT_VAR_CENTER = 3'd4,
        CFG_INIT_VAR_SIZE   = 3'd5,
        CFG_INIT_VAR_ANGLE  = 3'd6,
        CFG_INIT_VAR_RATE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DT_W-1:0]  dt;
        logic [VAR_W-1:0] q;
        logic [VAR_W-1:0] noise_c;
        logic [VAR_W-1:0] noise_s;
        logic [VAR_W-1:0] init_c;
        logic [VAR_W-1:0] init_s;
        logic [VAR_W-1:0] init_a;
        logic [VAR_W-1:0] init_r;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD,
        ST_MUL_RDT, ST_UPD_LEVEL, ST_MUL_DTPR, ST_SET_U,
        ST_MUL_DTPC, ST_SET_ACC, ST_MUL_DTU, ST_PRED_VAR,
        ST_INNOV, ST_DIV_K0, ST_SET_K0, ST_DIV_K1, ST_SET_K1,
        ST_MUL_K0E, ST_CORR_LEVEL, ST_MUL_K1E, ST_CORR_RATE,
        ST_MUL_PL, ST_CORR_PL, ST_MUL_K1PC, ST_CORR_PR,
        ST_MUL_PC, ST_CORR_PC, ST_STORE, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_LOAD,
        OP_MUL_RDT, OP_UPD_LEVEL, OP_MUL_DTPR, OP_SET_U,
        OP_MUL_DTPC, OP_SET_ACC, OP_MUL_DTU, OP_PRED_VAR,
        OP_INNOV, OP_DIV_STEP, OP_SET_K0, OP_SET_K1,
        OP_MUL_K0E, OP_CORR_LEVEL, OP_MUL_K1E, OP_CORR_RATE,
        OP_MUL_PL, OP_CORR_PL, OP_MUL_K1PC, OP_CORR_PR,
        OP_MUL_PC, OP_CORR_PC, OP_STORE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [LANE_W-1:0] lane;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic s_zero;
        logic correct;
    } t_status;

    // Round half up, then shift right by n (floor for either sign).
    function automatic logic signed [ACC_W-1:0] rs(input logic signed [ACC_W-1:0] x,
                                                  input int n);
        logic signed [ACC_W-1:0] half;
        half = '0;
        half[n-1] = 1'b1;
        return (x + half) >>> n;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = ACC_W'(-64'sd2147483648);
        if (x > hi) begin
            return 32'sh7fffffff;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[VAL_W-1:0];
    endfunction

    function automatic logic [VAR_W-1:0] satv(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        hi = ACC_W'(64'sd2147483647);
        if (x > hi) begin
            return '1;
        end else if (x < 0) begin
            return '0;
        end
        return x[VAR_W-1:0];
    endfunction

endpackage

@@ src/btkf_cfg.sv @@
module btkf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [btkf_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [btkf_pkg::VAR_W-1:0]    i_data,
    output btkf_pkg::t_cfg                o_cfg
);

    btkf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dt      <= btkf_pkg::RST_FRAME_INTERVAL;
            r_cfg.q       <= btkf_pkg::RST_PROCESS_NOISE;
            r_cfg.noise_c <= btkf_pkg::RST_NOISE_CENTER;
            r_cfg.noise_s <= btkf_pkg::RST_NOISE_SHAPE;
            r_cfg.init_c  <= btkf_pkg::RST_INIT_VAR_CENTER;
            r_cfg.init_s  <= btkf_pkg::RST_INIT_VAR_SIZE;
            r_cfg.init_a  <= btkf_pkg::RST_INIT_VAR_ANGLE;
            r_cfg.init_r  <= btkf_pkg::RST_INIT_VAR_RATE;
        end else if (i_we) begin
            case (btkf_pkg::t_cfg_idx'(i_idx))
                btkf_pkg::CFG_FRAME_INTERVAL:  r_cfg.dt      <= i_data[btkf_pkg::DT_W-1:0];
                btkf_pkg::CFG_PROCESS_NOISE:   r_cfg.q       <= i_data;
                btkf_pkg::CFG_NOISE_CENTER:    r_cfg.noise_c <= i_data;
                btkf_pkg::CFG_NOISE_SHAPE:     r_cfg.noise_s <= i_data;
                btkf_pkg::CFG_INIT_VAR_CENTER: r_cfg.init_c  <= i_data;
                btkf_pkg::CFG_INIT_VAR_SIZE:   r_cfg.init_s  <= i_data;
                btkf_pkg::CFG_INIT_VAR_ANGLE:  r_cfg.init_a  <= i_data;
                btkf_pkg::CFG_INIT_VAR_RATE:   r_cfg.init_r  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/btkf_ctrl.sv @@
module btkf_ctrl #(
    parameter int LANES = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    input  btkf_pkg::t_status i_status,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output btkf_pkg::t_cmd    o_cmd
);

    localparam int NL = (LANES < btkf_pkg::MAX_LANES) ? LANES : btkf_pkg::MAX_LANES;
    localparam logic [btkf_pkg::LANE_W-1:0] LAST_LANE = btkf_pkg::LANE_W'(NL - 1);

    btkf_pkg::t_state r_state, n_state;
    logic [btkf_pkg::LANE_W-1:0] r_lane, n_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btkf_pkg::ST_IDLE;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            r_lane  <= n_lane;
        end
    end

    always_comb begin
        n_state = r_state;
        n_lane  = r_lane;
        case (r_state)
            btkf_pkg::ST_IDLE: begin
                n_lane = '0;
                if (i_in_valid) begin
                    n_state = btkf_pkg::ST_LOAD;
                end
            end
            btkf_pkg::ST_LOAD:       n_state = btkf_pkg::ST_MUL_RDT;
            btkf_pkg::ST_MUL_RDT:    n_state = btkf_pkg::ST_UPD_LEVEL;
            btkf_pkg::ST_UPD_LEVEL:  n_state = btkf_pkg::ST_MUL_DTPR;
            btkf_pkg::ST_MUL_DTPR:   n_state = btkf_pkg::ST_SET_U;
            btkf_pkg::ST_SET_U:      n_state = btkf_pkg::ST_MUL_DTPC;
            btkf_pkg::ST_MUL_DTPC:   n_state = btkf_pkg::ST_SET_ACC;
            btkf_pkg::ST_SET_ACC:    n_state = btkf_pkg::ST_MUL_DTU;
            btkf_pkg::ST_MUL_DTU:    n_state = btkf_pkg::ST_PRED_VAR;
            btkf_pkg::ST_PRED_VAR: begin
                n_state = i_status.correct ? btkf_pkg::ST_INNOV : btkf_pkg::ST_STORE;
            end
            btkf_pkg::ST_INNOV:      n_state = btkf_pkg::ST_DIV_K0;
            btkf_pkg::ST_DIV_K0: begin
                // With no innovation variance both gains stay zero.
                if (i_status.s_zero) begin
                    n_state = btkf_pkg::ST_MUL_K0E;
                end else if (i_status.div_done) begin
                    n_state = btkf_pkg::ST_SET_K0;
                end
            end
            btkf_pkg::ST_SET_K0:     n_state = btkf_pkg::ST_DIV_K1;
            btkf_pkg::ST_DIV_K1: begin
                if (i_status.div_done) begin
                    n_state = btkf_pkg::ST_SET_K1;
                end
            end
            btkf_pkg::ST_SET_K1:     n_state = btkf_pkg::ST_MUL_K0E;
            btkf_pkg::ST_MUL_K0E:    n_state = btkf_pkg::ST_CORR_LEVEL;
            btkf_pkg::ST_CORR_LEVEL: n_state = btkf_pkg::ST_MUL_K1E;
            btkf_pkg::ST_MUL_K1E:    n_state = btkf_pkg::ST_CORR_RATE;
            btkf_pkg::ST_CORR_RATE:  n_state = btkf_pkg::ST_MUL_PL;
            btkf_pkg::ST_MUL_PL:     n_state = btkf_pkg::ST_CORR_PL;
            btkf_pkg::ST_CORR_PL:    n_state = btkf_pkg::ST_MUL_K1PC;
            btkf_pkg::ST_MUL_K1PC:   n_state = btkf_pkg::ST_CORR_PR;
            btkf_pkg::ST_CORR_PR:    n_state = btkf_pkg::ST_MUL_PC;
            btkf_pkg::ST_MUL_PC:     n_state = btkf_pkg::ST_CORR_PC;
            btkf_pkg::ST_CORR_PC:    n_state = btkf_pkg::ST_STORE;
            btkf_pkg::ST_STORE: begin
                if (r_lane == LAST_LANE) begin
                    n_state = btkf_pkg::ST_OUT;
                end else begin
                    n_lane  = r_lane + 1'b1;
                    n_state = btkf_pkg::ST_LOAD;
                end
            end
            btkf_pkg::ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = btkf_pkg::ST_IDLE;
                end
            end
            default: n_state = btkf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != btkf_pkg::ST_IDLE);
        o_out_valid = (r_state == btkf_pkg::ST_OUT);
        o_cmd.lane  = r_lane;
        case (r_state)
            btkf_pkg::ST_IDLE: begin
                o_cmd.op = i_in_valid ? btkf_pkg::OP_ACCEPT : btkf_pkg::OP_NONE;
            end
            btkf_pkg::ST_LOAD:       o_cmd.op = btkf_pkg::OP_LOAD;
            btkf_pkg::ST_MUL_RDT:    o_cmd.op = btkf_pkg::OP_MUL_RDT;
            btkf_pkg::ST_UPD_LEVEL:  o_cmd.op = btkf_pkg::OP_UPD_LEVEL;
            btkf_pkg::ST_MUL_DTPR:   o_cmd.op = btkf_pkg::OP_MUL_DTPR;
            btkf_pkg::ST_SET_U:      o_cmd.op = btkf_pkg::OP_SET_U;
            btkf_pkg::ST_MUL_DTPC:   o_cmd.op = btkf_pkg::OP_MUL_DTPC;
            btkf_pkg::ST_SET_ACC:    o_cmd.op = btkf_pkg::OP_SET_ACC;
            btkf_pkg::ST_MUL_DTU:    o_cmd.op = btkf_pkg::OP_MUL_DTU;
            btkf_pkg::ST_PRED_VAR:   o_cmd.op = btkf_pkg::OP_PRED_VAR;
            btkf_pkg::ST_INNOV:      o_cmd.op = btkf_pkg::OP_INNOV;
            btkf_pkg::ST_DIV_K0: begin
                o_cmd.op = (i_status.s_zero || i_status.div_done) ?
                           btkf_pkg::OP_NONE : btkf_pkg::OP_DIV_STEP;
            end
            btkf_pkg::ST_SET_K0:     o_cmd.op = btkf_pkg::OP_SET_K0;
            btkf_pkg::ST_DIV_K1: begin
                o_cmd.op = i_status.div_done ? btkf_pkg::OP_NONE : btkf_pkg::OP_DIV_STEP;
            end
            btkf_pkg::ST_SET_K1:     o_cmd.op = btkf_pkg::OP_SET_K1;
            btkf_pkg::ST_MUL_K0E:    o_cmd.op = btkf_pkg::OP_MUL_K0E;
            btkf_pkg::ST_CORR_LEVEL: o_cmd.op = btkf_pkg::OP_CORR_LEVEL;
            btkf_pkg::ST_MUL_K1E:    o_cmd.op = btkf_pkg::OP_MUL_K1E;
            btkf_pkg::ST_CORR_RATE:  o_cmd.op = btkf_pkg::OP_CORR_RATE;
            btkf_pkg::ST_MUL_PL:     o_cmd.op = btkf_pkg::OP_MUL_PL;
            btkf_pkg::ST_CORR_PL:    o_cmd.op = btkf_pkg::OP_CORR_PL;
            btkf_pkg::ST_MUL_K1PC:   o_cmd.op = btkf_pkg::OP_MUL_K1PC;
            btkf_pkg::ST_CORR_PR:    o_cmd.op = btkf_pkg::OP_CORR_PR;
            btkf_pkg::ST_MUL_PC:     o_cmd.op = btkf_pkg::OP_MUL_PC;
            btkf_pkg::ST_CORR_PC:    o_cmd.op = btkf_pkg::OP_CORR_PC;
            btkf_pkg::ST_STORE:      o_cmd.op = btkf_pkg::OP_STORE;
            default:                 o_cmd.op = btkf_pkg::OP_NONE;
        endcase
    end

endmodule

@@ src/btkf_dp.sv @@
module btkf_dp #(
    parameter int LANES         = 5,
    parameter int VAR_FRAC_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btkf_pkg::t_cfg                i_cfg,
    input  btkf_pkg::t_cmd                i_cmd,
    input  logic signed [btkf_pkg::VAL_W-1:0] i_meas [btkf_pkg::MAX_LANES],
    output btkf_pkg::t_status             o_status,
    output logic signed [btkf_pkg::VAL_W-1:0] o_est [btkf_pkg::MAX_LANES]
);

    localparam int NL  = (LANES < btkf_pkg::MAX_LANES) ? LANES : btkf_pkg::MAX_LANES;
    localparam int LW  = (NL > 1) ? $clog2(NL) : 1;
    localparam int AW  = btkf_pkg::ACC_W;
    localparam int DW  = btkf_pkg::VAR_W + VAR_FRAC_BITS + 1;
    localparam int CW  = $clog2(DW + 1);
    localparam int KW  = VAR_FRAC_BITS + 1;
    localparam logic [KW-1:0] ONE = {1'b1, {VAR_FRAC_BITS{1'b0}}};

    // Per-lane filter state.
    logic signed [btkf_pkg::VAL_W-1:0] r_lvl  [NL];
    logic signed [btkf_pkg::VAL_W-1:0] r_rate [NL];
    logic [btkf_pkg::VAR_W-1:0]        r_pl   [NL];
    logic [btkf_pkg::VAR_W-1:0]        r_pc   [NL];
    logic [btkf_pkg::VAR_W-1:0]        r_pr   [NL];
    logic signed [btkf_pkg::VAL_W-1:0] r_meas [NL];

    // Working registers of the lane in progress.
    logic signed [btkf_pkg::VAL_W-1:0] r_l;
    logic signed [btkf_pkg::VAL_W-1:0] r_r;
    logic [btkf_pkg::VAR_W-1:0]        r_wpl;
    logic [btkf_pkg::VAR_W-1:0]        r_wpc;
    logic [btkf_pkg::VAR_W-1:0]        r_wpr;
    logic [btkf_pkg::U_W-1:0]          r_u;
    logic signed [AW-1:0]              r_acc;
    logic signed [AW-1:0]              r_prod;
    logic signed [btkf_pkg::ERR_W-1:0] r_e;
    logic [btkf_pkg::SUM_W-1:0]        r_s;
    logic [KW-1:0]                     r_k0;
    logic [btkf_pkg::VAR_W-1:0]        r_k1;
    logic                              r_correct;
    logic                              r_seeded;

    // Restoring divider: one quotient bit a cycle, quotient builds in r_dvd.
    logic [DW-1:0]                     r_dvd;
    logic [btkf_pkg::SUM_W-1:0]        r_rem;
    logic [CW-1:0]                     r_cnt;

    logic [LW-1:0]                     lane;
    logic signed [btkf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [btkf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [AW-1:0]              mul_p;
    logic signed [AW-1:0]              p16;
    logic signed [AW-1:0]              pf;
    logic [KW-1:0]                     omk;
    logic [btkf_pkg::SUM_W-1:0]        s_sum;
    logic [btkf_pkg::VAR_W-1:0]        noise;
    logic [btkf_pkg::SUM_W:0]          trial;
    logic                              ge;
    logic                              meas_pos;

    assign lane  = i_cmd.lane[LW-1:0];
    assign noise = (i_cmd.lane < 3'd2) ? i_cfg.noise_c : i_cfg.noise_s;
    assign s_sum = btkf_pkg::SUM_W'(r_wpl) + btkf_pkg::SUM_W'(noise);
    assign omk   = ONE - r_k0;
    assign p16   = btkf_pkg::rs(r_prod, btkf_pkg::DT_FRAC);
    assign pf    = btkf_pkg::rs(r_prod, VAR_FRAC_BITS);
    assign trial = {r_rem, r_dvd[DW-1]};
    assign ge    = (trial >= {1'b0, r_s});
    assign meas_pos = (i_meas[0] > 0) && (i_meas[1] > 0) && (i_meas[2] > 0) &&
                      (i_meas[3] > 0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            btkf_pkg::OP_MUL_RDT: begin
                mul_a = btkf_pkg::MUL_A_W'(r_r);
                mul_b = btkf_pkg::MUL_B_W'(i_cfg.dt);
            end
            btkf_pkg::OP_MUL_DTPR: begin
                mul_a = btkf_pkg::MUL_A_W'(r_wpr);
                mul_b = btkf_pkg::MUL_B_W'(i_cfg.dt);
            end
            btkf_pkg::OP_MUL_DTPC: begin
                mul_a = btkf_pkg::MUL_A_W'(r_wpc);
                mul_b = btkf_pkg::MUL_B_W'(i_cfg.dt);
            end
            btkf_pkg::OP_MUL_DTU: begin
                mul_a = btkf_pkg::MUL_A_W'(r_u);
                mul_b = btkf_pkg::MUL_B_W'(i_cfg.dt);
            end
            btkf_pkg::OP_MUL_K0E: begin
                mul_a = btkf_pkg::MUL_A_W'(r_k0);
                mul_b = btkf_pkg::MUL_B_W'(r_e);
            end
            btkf_pkg::OP_MUL_K1E: begin
                mul_a = btkf_pkg::MUL_A_W'(r_k1);
                mul_b = btkf_pkg::MUL_B_W'(r_e);
            end
            btkf_pkg::OP_MUL_PL: begin
                mul_a = btkf_pkg::MUL_A_W'(r_wpl);
                mul_b = btkf_pkg::MUL_B_W'(omk);
            end
            btkf_pkg::OP_MUL_K1PC: begin
                mul_a = btkf_pkg::MUL_A_W'(r_k1);
                mul_b = btkf_pkg::MUL_B_W'(r_wpc);
            end
            btkf_pkg::OP_MUL_PC: begin
                mul_a = btkf_pkg::MUL_A_W'(r_wpc);
                mul_b = btkf_pkg::MUL_B_W'(omk);
            end
            default: ;
        endcase
    end

    assign mul_p = AW'(mul_a) * AW'(mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_cnt    <= '0;
        end else begin
            case (i_cmd.op)
                btkf_pkg::OP_ACCEPT:   r_seeded <= 1'b1;
                btkf_pkg::OP_INNOV:    r_cnt    <= CW'(DW);
                btkf_pkg::OP_SET_K0:   r_cnt    <= CW'(DW);
                btkf_pkg::OP_DIV_STEP: r_cnt    <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (i_cmd.op)
            btkf_pkg::OP_ACCEPT: begin
                r_correct <= meas_pos;
                for (int i = 0; i < NL; i++) begin
                    r_meas[i] <= i_meas[i];
                    if (!r_seeded) begin
                        r_lvl[i]  <= i_meas[i];
                        r_rate[i] <= '0;
                        r_pc[i]   <= '0;
                        r_pr[i]   <= i_cfg.init_r;
                        if (i < 2) begin
                            r_pl[i] <= i_cfg.init_c;
                        end else if (i < 4) begin
                            r_pl[i] <= i_cfg.init_s;
                        end else begin
                            r_pl[i] <= i_cfg.init_a;
                        end
                    end
                end
            end
            btkf_pkg::OP_LOAD: begin
                r_l   <= r_lvl[lane];
                r_r   <= r_rate[lane];
                r_wpl <= r_pl[lane];
                r_wpc <= r_pc[lane];
                r_wpr <= r_pr[lane];
            end
            btkf_pkg::OP_UPD_LEVEL: r_l <= btkf_pkg::sat32(AW'(r_l) + p16);
            btkf_pkg::OP_SET_U:     r_u <= p16[btkf_pkg::U_W-1:0];
            btkf_pkg::OP_SET_ACC: begin
                r_acc <= signed'(AW'(r_wpl)) + (p16 <<< 1) + signed'(AW'(i_cfg.q));
            end
            btkf_pkg::OP_PRED_VAR: begin
                r_wpl <= btkf_pkg::satv(r_acc + p16);
                r_wpc <= btkf_pkg::satv(signed'(AW'(r_wpc)) + signed'(AW'(r_u)));
                r_wpr <= btkf_pkg::satv(signed'(AW'(r_wpr)) + signed'(AW'(i_cfg.q)));
            end
            btkf_pkg::OP_INNOV: begin
                r_e   <= btkf_pkg::ERR_W'(r_meas[lane]) - btkf_pkg::ERR_W'(r_l);
                r_s   <= s_sum;
                r_k0  <= '0;
                r_k1  <= '0;
                r_rem <= '0;
                r_dvd <= (DW'(r_wpl) << VAR_FRAC_BITS) + DW'(s_sum[btkf_pkg::SUM_W-1:1]);
            end
            btkf_pkg::OP_DIV_STEP: begin
                r_rem <= ge ? btkf_pkg::SUM_W'(trial - {1'b0, r_s})
                            : trial[btkf_pkg::SUM_W-1:0];
                r_dvd <= {r_dvd[DW-2:0], ge};
            end
            btkf_pkg::OP_SET_K0: begin
                r_k0  <= r_dvd[KW-1:0];
                r_rem <= '0;
                r_dvd <= (DW'(r_wpc) << VAR_FRAC_BITS) + DW'(r_s[btkf_pkg::SUM_W-1:1]);
            end
            btkf_pkg::OP_SET_K1: begin
                r_k1 <= (|r_dvd[DW-1:btkf_pkg::VAR_W]) ? '1 : r_dvd[btkf_pkg::VAR_W-1:0];
            end
            btkf_pkg::OP_CORR_LEVEL: r_l   <= btkf_pkg::sat32(AW'(r_l) + pf);
            btkf_pkg::OP_CORR_RATE:  r_r   <= btkf_pkg::sat32(AW'(r_r) + pf);
            btkf_pkg::OP_CORR_PL:    r_wpl <= btkf_pkg::satv(pf);
            btkf_pkg::OP_CORR_PR:    r_wpr <= btkf_pkg::satv(signed'(AW'(r_wpr)) - pf);
            btkf_pkg::OP_CORR_PC:    r_wpc <= btkf_pkg::satv(pf);
            btkf_pkg::OP_STORE: begin
                r_lvl[lane]  <= r_l;
                r_rate[lane] <= r_r;
                r_pl[lane]   <= r_wpl;
                r_pc[lane]   <= r_wpc;
                r_pr[lane]   <= r_wpr;
            end
            default: ;
        endcase
    end

    assign o_status.div_done = (r_cnt == '0);
    assign o_status.s_zero   = (r_s == '0);
    assign o_status.correct  = r_correct;

    genvar g;
    generate
        for (g = 0; g < btkf_pkg::MAX_LANES; g++) begin : g_est
            if (g < NL) begin : g_on
                assign o_est[g] = r_lvl[g];
            end else begin : g_off
                assign o_est[g] = '0;
            end
        end
    endgenerate

endmodule

@@ src/box_tracking_kalman_filter_top.sv @@
// Channel   Direction  Handshake               Payload
// cfg       in         i_cfg_we                i_cfg_idx, i_cfg_data
// in        in         i_in_valid / o_in_stall i_meas_center_x .. i_meas_angle
// out       out        o_out_valid/i_out_stall o_est_center_x .. o_est_angle,
//                                              o_was_corrected
//
// One item at a time through a shared multiplier and a one-bit-a-cycle divider.
// Per lane: prediction, then for a corrected item the two gain divisions and the update.
// An item steps through L = min(LANES, 5) lanes, one lane after another.
// Reset is synchronous and active low; it restores the register defaults and unseeds.
// The result waits in place while the output is stalled; no new item is taken meanwhile.
module box_tracking_kalman_filter_top #(
    parameter int LANES         = 5,
    parameter int VAR_FRAC_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [btkf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [btkf_pkg::VAR_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [31:0]            i_meas_center_x,
    input  logic signed [31:0]            i_meas_center_y,
    input  logic signed [31:0]            i_meas_width,
    input  logic signed [31:0]            i_meas_height,
    input  logic signed [31:0]            i_meas_angle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [31:0]            o_est_center_x,
    output logic signed [31:0]            o_est_center_y,
    output logic signed [31:0]            o_est_width,
    output logic signed [31:0]            o_est_height,
    output logic signed [31:0]            o_est_angle,
    output logic                          o_was_corrected
);

    btkf_pkg::t_cfg    cfg;
    btkf_pkg::t_cmd    cmd;
    btkf_pkg::t_status status;
    logic signed [btkf_pkg::VAL_W-1:0] meas [btkf_pkg::MAX_LANES];
    logic signed [btkf_pkg::VAL_W-1:0] est  [btkf_pkg::MAX_LANES];

    assign meas[0] = i_meas_center_x;
    assign meas[1] = i_meas_center_y;
    assign meas[2] = i_meas_width;
    assign meas[3] = i_meas_height;
    assign meas[4] = i_meas_angle;

    btkf_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (i_cfg_we),
        .i_idx  (i_cfg_idx),
        .i_data (i_cfg_data),
        .o_cfg  (cfg)
    );

    btkf_ctrl #(
        .LANES(LANES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_cmd      (cmd)
    );

    btkf_dp #(
        .LANES        (LANES),
        .VAR_FRAC_BITS(VAR_FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .i_meas  (meas),
        .o_status(status),
        .o_est   (est)
    );

    assign o_est_center_x  = est[0];
    assign o_est_center_y  = est[1];
    assign o_est_width     = est[2];
    assign o_est_height    = est[3];
    assign o_est_angle     = est[4];
    assign o_was_corrected = status.correct;

endmodule

@@ src/btkf_checker.sv @@
`include "box_tracking_kalman_filter_top_defines.svh"

module btkf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_stall,
    input logic        i_out_valid,
    input logic        i_out_stall,
    input logic [31:0] i_est_center_x,
    input logic [31:0] i_est_center_y,
    input logic [31:0] i_est_width,
    input logic [31:0] i_est_height,
    input logic [31:0] i_est_angle,
    input logic        i_was_corrected
);

    // A waiting result keeps the input side closed.
    `BTKF_ASSERT_IMP(a_out_blocks_in, i_clk, i_rst_n, i_out_valid, i_in_stall)

    // Once an item is taken the block is busy with it.
    `BTKF_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !i_in_stall, i_in_stall)

    `BTKF_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)

    `BTKF_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_est_center_x) && $stable(i_est_center_y) && $stable(i_est_width) && $stable(i_est_height) && $stable(i_est_angle) && $stable(i_was_corrected))

endmodule

bind box_tracking_kalman_filter_top btkf_checker u_btkf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_stall     (o_in_stall),
    .i_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .i_est_center_x (o_est_center_x),
    .i_est_center_y (o_est_center_y),
    .i_est_width    (o_est_width),
    .i_est_height   (o_est_height),
    .i_est_angle    (o_est_angle),
    .i_was_corrected(o_was_corrected)
);
